// ===== hw/rtl/bnv_pkg.sv =====
// Shared types, constants and helper functions for the BGRA to NV12 converter.
package bnv_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int MAX_HEIGHT   = 4096;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int SIZE_W       = 13;
  localparam int STORE_DEPTH  = MAX_WIDTH / 2;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int CHAN_W       = 9;
  localparam int PAIR_W       = 2 * CHAN_W;
  localparam int LUMA_IDX_W   = 24;
  localparam int CHROMA_IDX_W = 23;
  localparam int CFG_IDX_W    = 1;
  localparam int MATH_W       = 18;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(1920);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(1080);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // BT.601 studio-swing weights
  localparam logic signed [MATH_W-1:0] COEF_Y_R  = 18'sd66;
  localparam logic signed [MATH_W-1:0] COEF_Y_G  = 18'sd129;
  localparam logic signed [MATH_W-1:0] COEF_Y_B  = 18'sd25;
  localparam logic signed [MATH_W-1:0] COEF_U_R  = -18'sd38;
  localparam logic signed [MATH_W-1:0] COEF_U_G  = -18'sd74;
  localparam logic signed [MATH_W-1:0] COEF_U_B  = 18'sd112;
  localparam logic signed [MATH_W-1:0] COEF_V_R  = 18'sd112;
  localparam logic signed [MATH_W-1:0] COEF_V_G  = -18'sd94;
  localparam logic signed [MATH_W-1:0] COEF_V_B  = -18'sd18;
  localparam logic signed [MATH_W-1:0] ROUND_ADD = 18'sd128;
  localparam logic signed [MATH_W-1:0] Y_OFFSET  = 18'sd16;
  localparam logic signed [MATH_W-1:0] C_OFFSET  = 18'sd128;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0]              luma;
    logic [LUMA_IDX_W-1:0]   luma_index;
    logic                    chroma_valid;
    logic [7:0]              cb_value;
    logic [7:0]              cr_value;
    logic [CHROMA_IDX_W-1:0] chroma_index;
    logic                    frame_end;
  } pixel_out_t;

  typedef struct packed {
    logic [7:0]        y;
    logic [CHAN_W-1:0] u;
    logic [CHAN_W-1:0] v;
  } yuv_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [PAIR_W-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } store_rd_t;

  function automatic logic [7:0] clamp_u8(input logic signed [MATH_W-1:0] val);
    logic [7:0] res;
    if (val < 0) begin
      res = 8'd0;
    end else if (val > 18'sd255) begin
      res = 8'd255;
    end else begin
      res = val[7:0];
    end
    return res;
  endfunction

  // Clamp to 2..limit, then force even.
  function automatic logic [SIZE_W-1:0] effective_size(input logic [SIZE_W-1:0] val,
                                                       input logic [SIZE_W-1:0] limit);
    logic [SIZE_W-1:0] s;
    s = val;
    if (s < SIZE_W'(2)) begin
      s = SIZE_W'(2);
    end
    if (s > limit) begin
      s = limit;
    end
    s[0] = 1'b0;
    return s;
  endfunction

endpackage

// ===== hw/rtl/bnv_pixel_math.sv =====
// Per-pixel BT.601 color-space conversion: luma byte and unaveraged U/V terms.
module bnv_pixel_math (
  input  bnv_pkg::pixel_in_t pix,
  output bnv_pkg::yuv_t      yuv
);

  logic signed [bnv_pkg::MATH_W-1:0] r_s;
  logic signed [bnv_pkg::MATH_W-1:0] g_s;
  logic signed [bnv_pkg::MATH_W-1:0] b_s;
  logic signed [bnv_pkg::MATH_W-1:0] y_sum;
  logic signed [bnv_pkg::MATH_W-1:0] u_sum;
  logic signed [bnv_pkg::MATH_W-1:0] v_sum;
  logic signed [bnv_pkg::MATH_W-1:0] y_full;
  logic signed [bnv_pkg::MATH_W-1:0] u_full;
  logic signed [bnv_pkg::MATH_W-1:0] v_full;

  always_comb begin
    r_s = $signed({10'b0, pix.red});
    g_s = $signed({10'b0, pix.green});
    b_s = $signed({10'b0, pix.blue});
    y_sum = bnv_pkg::COEF_Y_R * r_s + bnv_pkg::COEF_Y_G * g_s + bnv_pkg::COEF_Y_B * b_s
          + bnv_pkg::ROUND_ADD;
    u_sum = bnv_pkg::COEF_U_R * r_s + bnv_pkg::COEF_U_G * g_s + bnv_pkg::COEF_U_B * b_s
          + bnv_pkg::ROUND_ADD;
    v_sum = bnv_pkg::COEF_V_R * r_s + bnv_pkg::COEF_V_G * g_s + bnv_pkg::COEF_V_B * b_s
          + bnv_pkg::ROUND_ADD;
    // flooring shift, then offset
    y_full = (y_sum >>> 8) + bnv_pkg::Y_OFFSET;
    u_full = (u_sum >>> 8) + bnv_pkg::C_OFFSET;
    v_full = (v_sum >>> 8) + bnv_pkg::C_OFFSET;
    yuv.y = bnv_pkg::clamp_u8(y_full);
    yuv.u = u_full[bnv_pkg::CHAN_W-1:0];
    yuv.v = v_full[bnv_pkg::CHAN_W-1:0];
  end

endmodule

// ===== hw/rtl/bnv_line_store.sv =====
// Line store of even-row U/V pair sums, one entry per column pair, with write forwarding.
module bnv_line_store (
  input  logic                            clk,
  input  bnv_pkg::store_wr_t              wr,
  input  bnv_pkg::store_rd_t              rd,
  output logic [bnv_pkg::PAIR_W-1:0]      rd_data_r
);

  logic [bnv_pkg::PAIR_W-1:0] mem [bnv_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Forward a same-edge write to the same entry.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      if (wr.en && (wr.addr == rd.addr)) begin
        rd_data_r <= wr.data;
      end else begin
        rd_data_r <= mem[rd.addr];
      end
    end
  end

endmodule

// ===== hw/rtl/bgra_to_nv12_converter_core.sv =====
// Top level of the BGRA to NV12 converter: counters, pipeline and output register.
//
// Usage:
//   in_*  : one BGRA pixel per transaction (alpha not carried), raster order,
//           valid/ready handshake.
//   out_* : one result per pixel: luma byte and luma-plane offset; on the odd
//           row, odd column pixel of each 2x2 block also the averaged Cb/Cr
//           and interleaved chroma offset (chroma fields read zero otherwise);
//           frame_end marks the last pixel of the frame.
//   cfg_* : write-only registers frame_width (index 0) and frame_height
//           (index 1); write only while the pipeline is empty.
// Throughput: one pixel per clock while out_ready is high. The line store has one read and
//   one write per cycle, so the 2x2 accumulation never throttles the stream.
// Pipeline: the pixel register loads on the input transaction's edge (color
//   math behind it), then the converted pixel register loads together with
//   the line-store read, then the output register that drives out_valid.
// Reset: counters return to the frame origin, size registers to 1920x1080,
//   all stages empty. The line store is not cleared; every entry is written
//   on the even row before the odd row reads it.
// Stall: when out_ready is low the output holds and the stages fill up; the
//   input keeps accepting until every stage holds a pixel.
module bgra_to_nv12_converter_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bnv_pkg::pixel_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bnv_pkg::pixel_out_t               out_data,
  input  logic                              cfg_wr_en,
  input  logic [bnv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bnv_pkg::SIZE_W-1:0]        cfg_wdata
);

  localparam int CW = bnv_pkg::COL_W;
  localparam int RW = bnv_pkg::ROW_W;
  localparam int SW = bnv_pkg::SIZE_W;
  localparam int PW = bnv_pkg::CHAN_W;
  localparam int MW = bnv_pkg::MATH_W;
  localparam int PROD_W = RW + SW;

  // Configuration (already clamped and evened)
  logic [SW-1:0] width_r;
  logic [SW-1:0] height_r;

  // Frame position of the next input pixel
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [SW-1:0] col_inc;
  logic [SW-1:0] row_inc;
  logic          last_col;
  logic          last_row;

  // Stage 1: registered pixel and position
  logic                 s1_valid_r;
  bnv_pkg::pixel_in_t   s1_pix_r;
  logic [CW-1:0]        s1_col_r;
  logic [RW-1:0]        s1_row_r;
  logic [SW-1:0]        s1_width_r;
  logic                 s1_end_r;
  bnv_pkg::yuv_t        s1_yuv;
  logic [PROD_W-1:0]    s1_row_prod;
  logic [PROD_W-1:0]    s1_crow_prod;

  // Stage 2: converted pixel, offsets partly formed, store data arriving
  logic                                 s2_valid_r;
  bnv_pkg::yuv_t                        s2_yuv_r;
  logic [CW-1:0]                        s2_col_r;
  logic                                 s2_row_odd_r;
  logic                                 s2_end_r;
  logic [bnv_pkg::LUMA_IDX_W-1:0]       s2_row_base_r;
  logic [bnv_pkg::CHROMA_IDX_W-1:0]     s2_crow_base_r;

  // U/V terms of the even column of the current pair
  logic [bnv_pkg::PAIR_W-1:0] pair_r;

  // Output register
  logic                out_valid_r;
  bnv_pkg::pixel_out_t out_data_r;
  bnv_pkg::pixel_out_t out_data_nxt;

  logic s1_adv;
  logic s2_adv;
  logic in_acc;

  bnv_pkg::store_wr_t         st_wr;
  bnv_pkg::store_rd_t         st_rd;
  logic [bnv_pkg::PAIR_W-1:0] st_rd_data;

  logic [PW:0]   u_pair;
  logic [PW:0]   v_pair;
  logic [PW+1:0] u_quad;
  logic [PW+1:0] v_quad;

  // Pipeline flow control: a stage moves when the next one is empty or moving
  assign s2_adv   = s2_valid_r && (!out_valid_r || out_ready);
  assign s1_adv   = s1_valid_r && (!s2_valid_r || s2_adv);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // Position bookkeeping
  always_comb begin
    col_inc  = SW'(col_r) + SW'(1);
    row_inc  = SW'(row_r) + SW'(1);
    last_col = (col_inc >= width_r);
    last_row = (row_inc >= height_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bnv_pkg::WIDTH_RESET;
      height_r <= bnv_pkg::HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        bnv_pkg::REG_FRAME_WIDTH: begin
          width_r <= bnv_pkg::effective_size(cfg_wdata, SW'(bnv_pkg::MAX_WIDTH));
        end
        bnv_pkg::REG_FRAME_HEIGHT: begin
          height_r <= bnv_pkg::effective_size(cfg_wdata, SW'(bnv_pkg::MAX_HEIGHT));
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_inc[RW-1:0];
      end else begin
        col_r <= col_inc[CW-1:0];
      end
    end
  end

  // Stage 1: capture the pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r   <= in_data;
      s1_col_r   <= col_r;
      s1_row_r   <= row_r;
      s1_width_r <= width_r;
      s1_end_r   <= last_col && last_row;
    end
  end

  bnv_pixel_math u_math (
    .pix (s1_pix_r),
    .yuv (s1_yuv)
  );

  assign s1_row_prod  = PROD_W'(s1_row_r) * PROD_W'(s1_width_r);
  assign s1_crow_prod = PROD_W'(s1_row_r >> 1) * PROD_W'(s1_width_r);

  // Fetch the even-row pair sum as the pixel moves into stage 2
  always_comb begin
    st_rd.en   = s1_adv;
    st_rd.addr = s1_col_r[CW-1:1];
  end

  // Stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (!s2_valid_r || s2_adv) begin
      s2_valid_r <= s1_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_yuv_r       <= s1_yuv;
      s2_col_r       <= s1_col_r;
      s2_row_odd_r   <= s1_row_r[0];
      s2_end_r       <= s1_end_r;
      s2_row_base_r  <= s1_row_prod[bnv_pkg::LUMA_IDX_W-1:0];
      s2_crow_base_r <= s1_crow_prod[bnv_pkg::CHROMA_IDX_W-1:0];
    end
  end

  bnv_line_store u_store (
    .clk       (clk),
    .wr        (st_wr),
    .rd        (st_rd),
    .rd_data_r (st_rd_data)
  );

  // Accumulate the pair, then the 2x2 block
  always_comb begin
    u_pair = {1'b0, pair_r[bnv_pkg::PAIR_W-1:PW]} + {1'b0, s2_yuv_r.u};
    v_pair = {1'b0, pair_r[PW-1:0]} + {1'b0, s2_yuv_r.v};
    u_quad = {1'b0, u_pair} + {2'b0, st_rd_data[bnv_pkg::PAIR_W-1:PW]};
    v_quad = {1'b0, v_pair} + {2'b0, st_rd_data[PW-1:0]};

    st_wr.en   = s2_adv && s2_col_r[0] && !s2_row_odd_r;
    st_wr.addr = s2_col_r[CW-1:1];
    st_wr.data = {u_pair[PW-1:0], v_pair[PW-1:0]};

    out_data_nxt.luma         = s2_yuv_r.y;
    out_data_nxt.luma_index   = s2_row_base_r + bnv_pkg::LUMA_IDX_W'(s2_col_r);
    out_data_nxt.frame_end    = s2_end_r;
    out_data_nxt.chroma_valid = s2_col_r[0] && s2_row_odd_r;
    out_data_nxt.cb_value     = '0;
    out_data_nxt.cr_value     = '0;
    out_data_nxt.chroma_index = '0;
    if (out_data_nxt.chroma_valid) begin
      // divide by four with truncation
      out_data_nxt.cb_value     = bnv_pkg::clamp_u8(MW'(u_quad >> 2));
      out_data_nxt.cr_value     = bnv_pkg::clamp_u8(MW'(v_quad >> 2));
      out_data_nxt.chroma_index = s2_crow_base_r
                                + bnv_pkg::CHROMA_IDX_W'({s2_col_r[CW-1:1], 1'b0});
    end
  end

  // Hold the even-column terms for the odd column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_r <= '0;
    end else if (s2_adv && !s2_col_r[0]) begin
      pair_r <= {s2_yuv_r.u, s2_yuv_r.v};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s2_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/bnv_checker.sv =====
// Port-level assertions for the BGRA to NV12 converter, bound to the top level.
module bnv_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input bnv_pkg::pixel_out_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

  // Drop output valid right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A completed block sits on an odd column of an even-width frame
  a_chroma_odd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.chroma_valid |-> out_data.luma_index[0])
    else $error("chroma on even luma offset");

  // Zero chroma fields outside completed blocks
  a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.chroma_valid |->
      out_data.cb_value == 8'd0 && out_data.cr_value == 8'd0 &&
      out_data.chroma_index == '0)
    else $error("chroma fields set without a completed block");

  // Keep averaged chroma at or below the studio-swing peak of 240
  a_chroma_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.chroma_valid |->
      out_data.cb_value <= 8'd240 && out_data.cr_value <= 8'd240)
    else $error("chroma average out of range");

endmodule

bind bgra_to_nv12_converter_core bnv_checker u_bnv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== test/nv12_pixel_checker.sv =====
// Checker for the NV12 converter: predicts each converted pixel and compares it.
`timescale 1ns / 100ps

module nv12_pixel_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  bnv_pkg::pixel_in_t            in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  bnv_pkg::pixel_out_t           out_data,
  input  logic                          cfg_wr_en,
  input  logic [bnv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bnv_pkg::SIZE_W-1:0]    cfg_wdata,
  output int                            mismatch_count,
  output int                            awaited_count
);

  logic [bnv_pkg::SIZE_W-1:0] width_reg;
  logic [bnv_pkg::SIZE_W-1:0] height_reg;
  int                         col_pos;
  int                         row_pos;
  logic [bnv_pkg::CHAN_W-1:0] half_u;
  logic [bnv_pkg::CHAN_W-1:0] half_v;
  logic [bnv_pkg::CHAN_W-1:0] line_u [bnv_pkg::STORE_DEPTH];
  logic [bnv_pkg::CHAN_W-1:0] line_v [bnv_pkg::STORE_DEPTH];
  bnv_pkg::pixel_out_t        predicted_nv12 [$];
  int                         failures;

  function automatic int usable_size(logic [bnv_pkg::SIZE_W-1:0] setting, int limit);
    int s;
    s = setting;
    if (s < 2) s = 2;
    if (s > limit) s = limit;
    return s & ~1;
  endfunction

  // Convert one pixel and advance the raster position.
  function automatic bnv_pkg::pixel_out_t convert_pixel(bnv_pkg::pixel_in_t px);
    bnv_pkg::pixel_out_t res;
    int r, g, b, w, h, y, u, v, u_sum, v_sum, slot;
    r = px.red;
    g = px.green;
    b = px.blue;
    w = usable_size(width_reg, bnv_pkg::MAX_WIDTH);
    h = usable_size(height_reg, bnv_pkg::MAX_HEIGHT);
    y = ((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16;
    u = ((-38 * r - 74 * g + 112 * b + 128) >>> 8) + 128;
    v = ((112 * r - 94 * g - 18 * b + 128) >>> 8) + 128;
    res = '0;
    res.luma = (y < 0) ? 8'd0 : (y > 255) ? 8'd255 : 8'(y);
    res.luma_index = bnv_pkg::LUMA_IDX_W'(row_pos * w + col_pos);
    if (col_pos % 2 == 0) begin
      half_u = bnv_pkg::CHAN_W'(u);
      half_v = bnv_pkg::CHAN_W'(v);
    end else begin
      u_sum = int'(half_u) + u;
      v_sum = int'(half_v) + v;
      slot  = (col_pos / 2) % bnv_pkg::STORE_DEPTH;
      if (row_pos % 2 == 0) begin
        line_u[slot] = bnv_pkg::CHAN_W'(u_sum);
        line_v[slot] = bnv_pkg::CHAN_W'(v_sum);
      end else begin
        u_sum += int'(line_u[slot]);
        v_sum += int'(line_v[slot]);
        res.chroma_valid = 1'b1;
        res.cb_value     = (u_sum / 4 > 255) ? 8'd255 : 8'(u_sum / 4);
        res.cr_value     = (v_sum / 4 > 255) ? 8'd255 : 8'(v_sum / 4);
        res.chroma_index = bnv_pkg::CHROMA_IDX_W'((row_pos / 2) * w + (col_pos & ~1));
      end
    end
    res.frame_end = (col_pos + 1 >= w) && (row_pos + 1 >= h);
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return res;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      failures++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    bnv_pkg::pixel_out_t want;
    if (!rst_n) begin
      width_reg  = bnv_pkg::WIDTH_RESET;
      height_reg = bnv_pkg::HEIGHT_RESET;
      col_pos    = 0;
      row_pos    = 0;
      half_u     = '0;
      half_v     = '0;
      failures   = 0;
      predicted_nv12.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == bnv_pkg::REG_FRAME_WIDTH) width_reg = cfg_wdata;
        else if (cfg_index == bnv_pkg::REG_FRAME_HEIGHT) height_reg = cfg_wdata;
      end
      if (in_valid && in_ready) predicted_nv12 = {predicted_nv12, convert_pixel(in_data)};
      if (out_valid && out_ready) begin
        if (predicted_nv12.size() == 0) begin
          failures++;
          $display("%0t: pixel result mismatch, expected none, got luma %0d at index %0d",
                   $time, out_data.luma, out_data.luma_index);
        end else begin
          want = predicted_nv12.pop_front();
          check_field("luma", want.luma, out_data.luma);
          check_field("luma_index", want.luma_index, out_data.luma_index);
          check_field("chroma_valid", want.chroma_valid, out_data.chroma_valid);
          check_field("cb_value", want.cb_value, out_data.cb_value);
          check_field("cr_value", want.cr_value, out_data.cr_value);
          check_field("chroma_index", want.chroma_index, out_data.chroma_index);
          check_field("frame_end", want.frame_end, out_data.frame_end);
        end
      end
    end
    mismatch_count <= failures;
    awaited_count  <= predicted_nv12.size();
  end

endmodule

// ===== test/tb.sv =====
// Testbench top for the BGRA to NV12 converter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  bnv_pkg::pixel_in_t            in_data   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b1;
  bnv_pkg::pixel_out_t           out_data;
  logic                          cfg_wr_en = 1'b0;
  logic [bnv_pkg::CFG_IDX_W-1:0] cfg_index = bnv_pkg::REG_FRAME_WIDTH;
  logic [bnv_pkg::SIZE_W-1:0]    cfg_wdata = '0;
  int                            mismatch_count;
  int                            awaited_count;

  // Idle controls: sender gaps and receiver stalls, switched per phase.
  bit src_gaps_on    = 1'b1;
  bit sink_stalls_on = 1'b1;
  int stall_left     = 0;
  int random_sent    = 0;

  bgra_to_nv12_converter_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  nv12_pixel_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .awaited_count  (awaited_count)
  );

  always #4 clk = ~clk;

  // Receiver: drop out_ready in random bursts while stalls are on.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Offer one pixel and hold it until the transaction completes. An idle
  // gap may come first when sender gaps are on.
  task automatic push_pixel(bnv_pkg::pixel_in_t px);
    int gap;
    gap = 0;
    if (src_gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
  endtask

  // Random colour; now and then pin a channel to an extreme byte.
  function automatic bnv_pkg::pixel_in_t random_pixel();
    bnv_pkg::pixel_in_t px;
    px = bnv_pkg::pixel_in_t'(24'($urandom));
    if ($urandom_range(0, 7) == 0) px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    if ($urandom_range(0, 7) == 0) px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    if ($urandom_range(0, 7) == 0) px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return px;
  endfunction

  // Mostly small sizes; sometimes below range, odd, or (when allowed) beyond
  // the maximum. Widths stay within 32 columns so an odd row only reads
  // line store entries that the wide even row has already written.
  function automatic logic [bnv_pkg::SIZE_W-1:0] pick_size(bit allow_beyond);
    case ($urandom_range(0, 9))
      0:       return bnv_pkg::SIZE_W'($urandom_range(0, 1));
      1:       return allow_beyond ? bnv_pkg::SIZE_W'($urandom_range(4097, 8191))
                                   : bnv_pkg::SIZE_W'($urandom_range(1, 12) * 2);
      2:       return bnv_pkg::SIZE_W'($urandom_range(1, 16) * 2 + 1);
      default: return bnv_pkg::SIZE_W'($urandom_range(1, 12) * 2);
    endcase
  endfunction

  task automatic write_reg(logic [bnv_pkg::CFG_IDX_W-1:0] idx,
                           logic [bnv_pkg::SIZE_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Drop valid, wait until every predicted pixel has come out, then let the
  // pipeline latency pass so the core is truly empty.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_frame(logic [bnv_pkg::SIZE_W-1:0] w, logic [bnv_pkg::SIZE_W-1:0] h);
    settle();
    write_reg(bnv_pkg::REG_FRAME_WIDTH, w);
    write_reg(bnv_pkg::REG_FRAME_HEIGHT, h);
  endtask

  initial begin
    bnv_pkg::pixel_in_t px;
    logic [7:0]         lvl;
    int                 n;

    // Hold reset at the start, release it once.
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: both sizes below range give 2x2 frames, so every fourth
    // transaction closes a chroma block. Walk the colour cube corners at
    // full, mid and low level; 24 pixels end on a frame boundary.
    set_frame(bnv_pkg::SIZE_W'(0), bnv_pkg::SIZE_W'(1));
    for (int i = 0; i < 24; i++) begin
      lvl      = (i < 8) ? 8'hFF : (i < 16) ? 8'h80 : 8'h01;
      px.blue  = i[0] ? lvl : 8'h00;
      px.green = i[1] ? lvl : 8'h00;
      px.red   = i[2] ? lvl : 8'h00;
      push_pixel(px);
    end

    // Widest frame with an odd height (rounds to 2): part of the even row
    // writes the low line store entries, which cover every column pair
    // that the narrow frames after it can reach.
    set_frame(bnv_pkg::SIZE_W'(4096), bnv_pkg::SIZE_W'(3));
    repeat (200) push_pixel(random_pixel());

    // Tallest setting with a width below range; the column left by the wide
    // frame wraps at once. Stop well inside the frame so the next size
    // change lands mid frame and the row counter wraps.
    set_frame(bnv_pkg::SIZE_W'(1), bnv_pkg::SIZE_W'(8191));
    repeat (150) push_pixel(random_pixel());

    // Random phases: new sizes at whatever raster position the last phase
    // left, idling switched on and off per phase.
    while (random_sent < 750) begin
      src_gaps_on    = ($urandom_range(0, 3) != 0);
      sink_stalls_on = ($urandom_range(0, 3) != 0);
      set_frame(pick_size(1'b0), pick_size(1'b1));
      n = $urandom_range(10, 120);
      repeat (n) push_pixel(random_pixel());
      random_sent += n;
    end

    // Last stretch at full rate: no gaps, no stalls.
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    set_frame(pick_size(1'b0), pick_size(1'b1));
    repeat (150) push_pixel(random_pixel());

    settle();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
